// ===== sv/rbd_pkg.sv =====
// Shared constants, types and helpers for the 2x2 RGB box downsampler.
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int MAX_SRC_W   = 4096;
  localparam int STORE_DEPTH = MAX_SRC_W / 2;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_SRC_W);
  localparam int HEIGHT_LIM  = 4096;
  localparam int ROW_W       = $clog2(HEIGHT_LIM);
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int PIX_W       = 8;
  localparam int SUM_W       = PIX_W + 1;
  localparam int ENTRY_W     = 3 * SUM_W;
  localparam int WCMP_W      = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int HCMP_W      = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = CFG_W'(480);

  // At most one line store access per accepted pixel, plus the block context.
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] pair_sum;
    logic               row_end;
    logic               frame_end;
  } line_op_t;

  // Clamp to the maximum source width, force even, at least 2.
  function automatic logic [COL_W:0] eff_width(input logic [CFG_W-1:0] v);
    logic [WCMP_W-1:0] x;
    x = WCMP_W'(v);
    if (x > WCMP_W'(MAX_SRC_W)) x = WCMP_W'(MAX_SRC_W);
    x[0] = 1'b0;
    if (x < WCMP_W'(2)) x = WCMP_W'(2);
    return x[COL_W:0];
  endfunction

  function automatic logic [ROW_W:0] eff_height(input logic [CFG_W-1:0] v);
    logic [HCMP_W-1:0] x;
    x = HCMP_W'(v);
    if (x > HCMP_W'(HEIGHT_LIM)) x = HCMP_W'(HEIGHT_LIM);
    x[0] = 1'b0;
    if (x < HCMP_W'(2)) x = HCMP_W'(2);
    return x[ROW_W:0];
  endfunction

  // sum/4 rounded half up.
  function automatic logic [PIX_W-1:0] avg4(input logic [SUM_W:0] s);
    logic [SUM_W-1:0] t;
    t = SUM_W'(s >> 2) + SUM_W'(s[1]);
    return t[PIX_W-1:0];
  endfunction

endpackage

// ===== sv/rbd_ram.sv =====
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module rbd_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 27,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rbd_ctrl.sv =====
// Config registers, raster counters, held pixel and line store requests.
`timescale 1ns / 1ps
module rbd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         accept_i,
  input  logic [rbd_pkg::PIX_W-1:0]    red_i,
  input  logic [rbd_pkg::PIX_W-1:0]    green_i,
  input  logic [rbd_pkg::PIX_W-1:0]    blue_i,
  input  logic                         frame_start_i,
  output rbd_pkg::line_op_t            op_o
);
  import rbd_pkg::*;

  logic [CFG_W-1:0]   src_width_q, src_height_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [3*PIX_W-1:0] held_q;

  logic [COL_W:0] w_eff, col0, col1, col_p;
  logic [ROW_W:0] h_eff, row0, row1, row2, row_p;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic row_last;

  assign w_eff = eff_width(src_width_q);
  assign h_eff = eff_height(src_height_q);

  always_comb begin
    col0 = frame_start_i ? '0 : (COL_W + 1)'(col_q);
    row0 = frame_start_i ? '0 : (ROW_W + 1)'(row_q);
    // wrap counters left out of range by a register change
    if (col0 >= w_eff) begin
      col1 = '0;
      row1 = row0 + (ROW_W + 1)'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    row2 = (row1 >= h_eff) ? '0 : row1;
    col  = col1[COL_W-1:0];
    row  = row2[ROW_W-1:0];

    col_p    = (COL_W + 1)'(col) + (COL_W + 1)'(1);
    row_p    = (ROW_W + 1)'(row) + (ROW_W + 1)'(1);
    row_last = (col_p >= w_eff);
    if (row_last) begin
      col_d = '0;
      row_d = (row_p >= h_eff) ? '0 : row_p[ROW_W-1:0];
    end else begin
      col_d = col_p[COL_W-1:0];
      row_d = row;
    end

    sum_r = SUM_W'(held_q[3*PIX_W-1:2*PIX_W]) + SUM_W'(red_i);
    sum_g = SUM_W'(held_q[2*PIX_W-1:PIX_W]) + SUM_W'(green_i);
    sum_b = SUM_W'(held_q[PIX_W-1:0]) + SUM_W'(blue_i);

    op_o.wr        = accept_i && col[0] && !row[0];
    op_o.rd        = accept_i && col[0] && row[0];
    op_o.slot      = col[COL_W-1:1];
    op_o.pair_sum  = {sum_r, sum_g, sum_b};
    op_o.row_end   = row_last;
    op_o.frame_end = row_last && (row_p >= h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_WIDTH_RST;
      src_height_q <= SRC_HEIGHT_RST;
      col_q        <= '0;
      row_q        <= '0;
      held_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
          REG_SRC_HEIGHT: src_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!col[0]) begin
          held_q <= {red_i, green_i, blue_i};
        end
      end
    end
  end

endmodule

// ===== sv/rbd_out.sv =====
// Block sum, rounding and output register with stall handling.
`timescale 1ns / 1ps
module rbd_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbd_pkg::line_op_t            op_i,
  input  logic [rbd_pkg::ENTRY_W-1:0]  rd_data_i,
  input  logic                         out_stall_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  output logic [rbd_pkg::PIX_W-1:0]    red_o,
  output logic [rbd_pkg::PIX_W-1:0]    green_o,
  output logic [rbd_pkg::PIX_W-1:0]    blue_o,
  output logic                         row_end_o,
  output logic                         frame_end_o
);
  import rbd_pkg::*;

  logic               s1_valid_q;
  logic [ENTRY_W-1:0] s1_sum_q;
  logic               s1_row_end_q, s1_frame_end_q;
  logic               out_valid_q;
  logic [PIX_W-1:0]   red_q, green_q, blue_q;
  logic               row_end_q, frame_end_q;
  logic               out_free, s1_adv;
  logic [SUM_W:0]     tot_r, tot_g, tot_b;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  // hold input while the read data waits behind a full output
  assign in_stall_o = s1_valid_q && !out_free;

  assign tot_r = (SUM_W + 1)'(s1_sum_q[3*SUM_W-1:2*SUM_W])
               + (SUM_W + 1)'(rd_data_i[3*SUM_W-1:2*SUM_W]);
  assign tot_g = (SUM_W + 1)'(s1_sum_q[2*SUM_W-1:SUM_W])
               + (SUM_W + 1)'(rd_data_i[2*SUM_W-1:SUM_W]);
  assign tot_b = (SUM_W + 1)'(s1_sum_q[SUM_W-1:0])
               + (SUM_W + 1)'(rd_data_i[SUM_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i.rd) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.rd) begin
      s1_sum_q       <= op_i.pair_sum;
      s1_row_end_q   <= op_i.row_end;
      s1_frame_end_q <= op_i.frame_end;
    end
    if (s1_adv) begin
      red_q       <= avg4(tot_r);
      green_q     <= avg4(tot_g);
      blue_q      <= avg4(tot_b);
      row_end_q   <= s1_row_end_q;
      frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

// ===== sv/rgb_box_downsample_2x2_top.sv =====
// Top level of the 2x2 RGB box downsampler.
// An odd-row, odd-column pixel yields a word via the read/sum and output registers.
// Throughput: one pixel per clock unless stalled; at most one line store access each.
// The line store is a single-port RAM of 2048 x 27 bits with registered read data.
// Reset clears counters, held pixel and output valid; width and height go to 640 x 480.
// The line store is not cleared; each odd row reads what its even row wrote.
`timescale 1ns / 1ps
module rgb_box_downsample_2x2_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rbd_pkg::PIX_W-1:0]    red_in_i,
  input  logic [rbd_pkg::PIX_W-1:0]    green_in_i,
  input  logic [rbd_pkg::PIX_W-1:0]    blue_in_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rbd_pkg::PIX_W-1:0]    red_out_o,
  output logic [rbd_pkg::PIX_W-1:0]    green_out_o,
  output logic [rbd_pkg::PIX_W-1:0]    blue_out_o,
  output logic                         row_end_o,
  output logic                         frame_end_o
);
  import rbd_pkg::*;

  logic               accept;
  line_op_t           op;
  logic [ENTRY_W-1:0] rd_data;

  assign accept = in_valid_i && !in_stall_o;

  rbd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .red_i         (red_in_i),
    .green_i       (green_in_i),
    .blue_i        (blue_in_i),
    .frame_start_i (frame_start_i),
    .op_o          (op)
  );

  rbd_ram #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (op.wr),
    .re_i    (op.rd),
    .addr_i  (op.slot),
    .wdata_i (op.pair_sum),
    .rdata_o (rd_data)
  );

  rbd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .rd_data_i   (rd_data),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  a_store_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(op.wr && op.rd))
    else $error("line store read and written in one cycle");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output can move");

  a_frame_end_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> row_end_o)
    else $error("frame end without row end");

  a_read_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op.rd && !out_valid_o) |=> ##1 out_valid_o)
    else $error("line store read did not produce a word");

endmodule

// ===== dv/rbd_checker.sv =====
// Checker for the 2x2 RGB box downsampler: predicts block averages and compares output words.
`timescale 1ns / 1ps
module rbd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [rbd_pkg::PIX_W-1:0]     red_in_i,
  input  logic [rbd_pkg::PIX_W-1:0]     green_in_i,
  input  logic [rbd_pkg::PIX_W-1:0]     blue_in_i,
  input  logic                          frame_start_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [rbd_pkg::PIX_W-1:0]     red_out_i,
  input  logic [rbd_pkg::PIX_W-1:0]     green_out_i,
  input  logic [rbd_pkg::PIX_W-1:0]     blue_out_i,
  input  logic                          row_end_i,
  input  logic                          frame_end_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int SIZE_LIMIT = 4096;
  localparam int SLOTS      = SIZE_LIMIT / 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       frame_end;
    logic       colors_known;
  } avg_word_t;

  avg_word_t   block_averages_q[$];
  logic [26:0] pair_sums [SLOTS];
  // Slots never written hold no defined sum; their block colors are not compared.
  bit          pair_written [SLOTS];
  logic [23:0] held_px;
  logic [12:0] col_cnt;
  logic [12:0] row_cnt;
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  int          mismatches = 0;
  int          words_checked = 0;

  // Clamp to the limit, clear bit 0, never below 2.
  function automatic logic [12:0] even_size(input logic [12:0] v);
    logic [12:0] x;
    x = (v > 13'(SIZE_LIMIT)) ? 13'(SIZE_LIMIT) : v;
    x[0] = 1'b0;
    if (x < 13'd2) x = 13'd2;
    return x;
  endfunction

  // Quarter of a four-pixel sum, half rounded up.
  function automatic logic [7:0] quarter_round(input logic [9:0] s);
    logic [9:0] q;
    q = s / 4 + (s % 4) / 2;
    return q[7:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR word %0d: %s got %0d, want %0d", words_checked, what, got, want);
    mismatches++;
  endtask

  task automatic predict_block_average(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic fs);
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] col;
    logic [12:0] row;
    logic [8:0]  sr;
    logic [8:0]  sg;
    logic [8:0]  sb;
    logic [9:0]  tr;
    logic [9:0]  tg;
    logic [9:0]  tb;
    logic [26:0] entry;
    avg_word_t   word;
    w = even_size(width_reg);
    h = even_size(height_reg);
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    // Wrap counters left out of range by a register change.
    if (col_cnt >= w) begin
      col_cnt = '0;
      row_cnt = row_cnt + 13'd1;
    end
    if (row_cnt >= h) row_cnt = '0;
    col = col_cnt;
    row = row_cnt;
    if (!col[0]) begin
      held_px = {r, g, b};
    end else begin
      sr = {1'b0, held_px[23:16]} + {1'b0, r};
      sg = {1'b0, held_px[15:8]} + {1'b0, g};
      sb = {1'b0, held_px[7:0]} + {1'b0, b};
      if (!row[0]) begin
        pair_sums[col[11:1]]    = {sr, sg, sb};
        pair_written[col[11:1]] = 1'b1;
      end else begin
        entry = pair_sums[col[11:1]];
        tr = {1'b0, sr} + {1'b0, entry[26:18]};
        tg = {1'b0, sg} + {1'b0, entry[17:9]};
        tb = {1'b0, sb} + {1'b0, entry[8:0]};
        word.red          = quarter_round(tr);
        word.green        = quarter_round(tg);
        word.blue         = quarter_round(tb);
        word.row_end      = (col + 13'd1 >= w);
        word.frame_end    = word.row_end && (row + 13'd1 >= h);
        word.colors_known = pair_written[col[11:1]];
        block_averages_q.push_back(word);
      end
    end
    col_cnt = col + 13'd1;
    if (col_cnt >= w) begin
      col_cnt = '0;
      row_cnt = row + 13'd1;
      if (row_cnt >= h) row_cnt = '0;
    end
  endtask

  task automatic check_word();
    avg_word_t want;
    if (block_averages_q.size() == 0) begin
      report_mismatch("word with nothing pending", 1, 0);
    end else begin
      want = block_averages_q.pop_front();
      if (want.colors_known) begin
        if (red_out_i !== want.red) begin
          report_mismatch("red_out", int'(red_out_i), int'(want.red));
        end
        if (green_out_i !== want.green) begin
          report_mismatch("green_out", int'(green_out_i), int'(want.green));
        end
        if (blue_out_i !== want.blue) begin
          report_mismatch("blue_out", int'(blue_out_i), int'(want.blue));
        end
      end
      if (row_end_i !== want.row_end) begin
        report_mismatch("row_end", int'(row_end_i), int'(want.row_end));
      end
      if (frame_end_i !== want.frame_end) begin
        report_mismatch("frame_end", int'(frame_end_i), int'(want.frame_end));
      end
    end
    words_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_px    = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      width_reg  = rbd_pkg::SRC_WIDTH_RST;
      height_reg = rbd_pkg::SRC_HEIGHT_RST;
      block_averages_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rbd_pkg::REG_SRC_WIDTH) width_reg = cfg_data_i;
        else if (cfg_idx_i == rbd_pkg::REG_SRC_HEIGHT) height_reg = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_i) begin
        predict_block_average(red_in_i, green_in_i, blue_in_i, frame_start_i);
      end
      pending_o    <= block_averages_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the 2x2 RGB box downsampler: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_PIXELS  = 1300;
  localparam int SEGMENT_CAP    = 400;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [rbd_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [rbd_pkg::PIX_W-1:0]     red_in;
  logic [rbd_pkg::PIX_W-1:0]     green_in;
  logic [rbd_pkg::PIX_W-1:0]     blue_in;
  logic                          frame_start;
  logic                          out_valid;
  logic                          out_stall;
  logic [rbd_pkg::PIX_W-1:0]     red_out;
  logic [rbd_pkg::PIX_W-1:0]     green_out;
  logic [rbd_pkg::PIX_W-1:0]     blue_out;
  logic                          row_end;
  logic                          frame_end;
  int                            fail_count;
  int                            pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int pixels_sent    = 0;
  int words_seen     = 0;
  int cfg_writes     = 0;
  int cur_w          = 640;
  int cur_h          = 480;

  rgb_box_downsample_2x2_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .row_end_o     (row_end),
    .frame_end_o   (frame_end)
  );

  rbd_checker avg_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .red_out_i     (red_out),
    .green_out_i   (green_out),
    .blue_out_i    (blue_out),
    .row_end_i     (row_end),
    .frame_end_i   (frame_end),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) words_seen++;
  end

  function automatic logic [7:0] pick_level();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 8'h00;
    if (p == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Mostly tiny frames, now and then medium ones, rarely the full 4096.
  function automatic int pick_size(input int big_pct);
    int p;
    p = $urandom_range(99);
    if (p < big_pct) return 4096;
    if (p < 20) return 2 * $urandom_range(5, 32);
    return 2 * $urandom_range(1, 4);
  endfunction

  // Register value that lands on the given even size: exact, odd, below 2 or clamped.
  function automatic int reg_value(input int size);
    int p;
    p = $urandom_range(3);
    if (size == 2 && p == 0) return $urandom_range(1);
    if (size == 4096 && p != 0) return $urandom_range(4097, 8191);
    return (p == 1) ? size + 1 : size;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    red_in      <= r;
    green_in    <= g;
    blue_in     <= b;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Hold the sender until every pending word is out and the pipe has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rbd_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= rbd_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic random_segment(input bit force_tall);
    int  n;
    int  k;
    bit  new_frame;
    if (force_tall || $urandom_range(99) < 40) begin
      wait_drained();
      if ($urandom_range(99) < 60) begin
        cur_w = pick_size(4);
        write_reg(rbd_pkg::REG_SRC_WIDTH, reg_value(cur_w));
      end
      if (force_tall || $urandom_range(99) < 60) begin
        cur_h = force_tall ? 4096 : pick_size(8);
        write_reg(rbd_pkg::REG_SRC_HEIGHT, reg_value(cur_h));
      end
    end
    n = cur_w * cur_h;
    if (n > SEGMENT_CAP) n = $urandom_range(100, SEGMENT_CAP);
    // Cut some frames short and start some mid-stream.
    if ($urandom_range(99) < 15) n = $urandom_range(1, n);
    new_frame = ($urandom_range(99) < 85);
    for (k = 0; k < n; k++) begin
      send_pixel(pick_level(), pick_level(), pick_level(),
                 (k == 0 && new_frame) || ($urandom_range(99) == 0));
    end
  endtask

  initial begin
    int base;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= rbd_pkg::REG_SRC_WIDTH;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    red_in      <= '0;
    green_in    <= '0;
    blue_in     <= '0;
    frame_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 20;
    recv_stall_pct = 74;

    // Odd width and height below 2 both fall back to 2x2.
    write_reg(rbd_pkg::REG_SRC_WIDTH, 3);
    write_reg(rbd_pkg::REG_SRC_HEIGHT, 1);
    for (int i = 0; i < 4; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
    // Block sums of 1, 2 and 3 per channel exercise the rounding.
    send_pixel(8'd1, 8'd1, 8'd1, 1'b1);
    send_pixel(8'd0, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    // Restart the frame halfway through.
    send_pixel(8'd9, 8'd9, 8'd9, 1'b1);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b1);
    send_pixel(8'd201, 8'd101, 8'd51, 1'b0);
    send_pixel(8'd202, 8'd102, 8'd52, 1'b0);
    send_pixel(8'd203, 8'd103, 8'd53, 1'b0);

    wait_drained();
    write_reg(rbd_pkg::REG_SRC_WIDTH, 4);
    write_reg(rbd_pkg::REG_SRC_HEIGHT, 4);
    send_pixel(8'd255, 8'd0, 8'd170, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd85, 1'b0);
    send_pixel(8'd128, 8'd127, 8'd1, 1'b0);
    send_pixel(8'd127, 8'd128, 8'd254, 1'b0);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(8'd4, 8'd5, 8'd6, 1'b0);
    // Shrink the width mid-row: the column count wraps and the row advances.
    wait_drained();
    write_reg(rbd_pkg::REG_SRC_WIDTH, 2);
    cur_w = 2;
    cur_h = 4;
    send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(8'd40, 8'd50, 8'd60, 1'b0);
    send_pixel(8'd70, 8'd80, 8'd90, 1'b0);
    send_pixel(8'd100, 8'd110, 8'd120, 1'b0);

    send_idle_pct  = 74;
    recv_stall_pct = 20;
    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      if (pixels_sent - base >= RANDOM_PIXELS / 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      random_segment(pixels_sent == base);
    end

    wait_drained();
    $display("Summary: %0d source pixels, %0d averaged words, %0d register writes",
             pixels_sent, words_seen, cfg_writes);
    $display("Summary: frames from 2x2 up to 4096 wide and tall, %s",
             "odd and clamped sizes, three idle mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Abort when nothing moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rbd_pkg.sv
sv/rbd_ram.sv
sv/rbd_ctrl.sv
sv/rbd_out.sv
sv/rgb_box_downsample_2x2_top.sv
dv/rbd_checker.sv
dv/tb_top.sv
